// ===== rtl/tlb_page_translation_fifo_assert.svh =====
// Assertion macros for the page translation block.
// Each macro takes a label, an antecedent, a consequent and a message.
// The macros use the clk and arst_n of the module that expands them.
`ifndef TLB_PAGE_TRANSLATION_FIFO_ASSERT_SVH
`define TLB_PAGE_TRANSLATION_FIFO_ASSERT_SVH

`ifndef SYNTHESIS

// Check the consequent in the same cycle as the antecedent.
`define TPTF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define TPTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TPTF_ASSERT_NOW(lbl, ante, cons, msg)
`define TPTF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/tlbpf_pkg.sv =====
package tlbpf_pkg;

	// Sizing of the translation structures
	localparam int TLB_ENTRIES = 16;
	localparam int FRAME_COUNT = 128;
	localparam int OFFSET_BITS = 8;

	// Field widths
	localparam int ADDR_W    = 16;
	localparam int PA_W      = 15;
	localparam int OUTCOME_W = 2;
	localparam int VPAGE_W   = 8;
	localparam int CFG_W     = 8;

	// Derived widths
	localparam int PAGE_W      = ADDR_W - OFFSET_BITS;
	localparam int TLB_IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int FRAME_IDX_W = $clog2(FRAME_COUNT);
	localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
	localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	// Stream packing
	localparam int S_TDATA_W = ADDR_W;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 3;
	localparam int M_PAD_W   = M_TDATA_W - PA_W - VPAGE_W;

	// Frame count register after reset
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(128);

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_TLB_HIT = 2'd0,
		OUT_PT_HIT  = 2'd1,
		OUT_FAULT   = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		FS_NONE   = 2'd0,
		FS_TLB    = 2'd1,
		FS_WALK   = 2'd2,
		FS_VICTIM = 2'd3
	} frame_sel_t;

	typedef struct packed {
		logic       capture;
		logic       walk_clear;
		logic       walk_issue;
		logic       victim_read;
		logic       fault_commit;
		frame_sel_t frame_sel;
		logic       res_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic tlb_hit;
		logic walk_hit;
		logic walk_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/tlbpf_ctrl.sv =====
module tlbpf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tlbpf_pkg::dp_status_t status,
	output tlbpf_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOOKUP = 6'b000010,
		S_WALK   = 6'b000100,
		S_VREAD  = 6'b001000,
		S_COMMIT = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Sequence one request through lookup, walk and fault handling
	always_comb begin
		state_nxt        = state_q;
		cmd.capture      = 1'b0;
		cmd.walk_clear   = 1'b0;
		cmd.walk_issue   = 1'b0;
		cmd.victim_read  = 1'b0;
		cmd.fault_commit = 1'b0;
		cmd.frame_sel    = tlbpf_pkg::FS_NONE;
		cmd.res_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (status.tlb_hit) begin
					cmd.frame_sel = tlbpf_pkg::FS_TLB;
					state_nxt     = S_DONE;
				end else begin
					cmd.walk_clear = 1'b1;
					state_nxt      = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_issue = 1'b1;
				if (status.walk_hit) begin
					cmd.frame_sel = tlbpf_pkg::FS_WALK;
					state_nxt     = S_DONE;
				end else if (status.walk_last) begin
					state_nxt = S_VREAD;
				end
			end
			S_VREAD: begin
				cmd.victim_read = 1'b1;
				cmd.frame_sel   = tlbpf_pkg::FS_VICTIM;
				state_nxt       = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.fault_commit = 1'b1;
				state_nxt        = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Accept a request only between translations
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/tlbpf_dp.sv =====
module tlbpf_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tlbpf_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic [tlbpf_pkg::ADDR_W-1:0]          in_addr,
	input  tlbpf_pkg::ctrl_cmd_t                  cmd,
	output tlbpf_pkg::dp_status_t                 status,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [tlbpf_pkg::PA_W-1:0]            out_pa,
	output logic [tlbpf_pkg::OUTCOME_W-1:0]       out_outcome,
	output logic                                  out_vic_valid,
	output logic [tlbpf_pkg::VPAGE_W-1:0]         out_vic_page
);

	localparam int FIW = tlbpf_pkg::FRAME_IDX_W;
	localparam int PGW = tlbpf_pkg::PAGE_W;
	localparam int TIW = tlbpf_pkg::TLB_IDX_W;
	localparam int CMW = tlbpf_pkg::CMP_W;

	// Request and result holding
	logic [tlbpf_pkg::ADDR_W-1:0]      addr_q;
	logic [FIW-1:0]                    frame_q;
	tlbpf_pkg::outcome_t               outcome_q;
	logic                              vic_vld_q;
	logic [tlbpf_pkg::VPAGE_W-1:0]     vic_page_q;
	logic [tlbpf_pkg::CFG_W-1:0]       cfg_q;

	// TLB
	logic [PGW-1:0]                    tlb_tag_q   [tlbpf_pkg::TLB_ENTRIES];
	logic [FIW-1:0]                    tlb_frame_q [tlbpf_pkg::TLB_ENTRIES];
	logic [tlbpf_pkg::TLB_ENTRIES-1:0] tlb_valid_q;
	logic [TIW-1:0]                    fill_q;

	// Inverted page table
	logic [PGW-1:0]                    owner_mem [tlbpf_pkg::FRAME_COUNT];
	logic [tlbpf_pkg::FRAME_COUNT-1:0] frame_valid_q;
	logic [FIW-1:0]                    walk_idx_q;
	logic [FIW-1:0]                    nv_q;

	// Table read stage
	logic [PGW-1:0]                    owner_rd_s1;
	logic [FIW-1:0]                    idx_s1;
	logic                              own_vld_s1;
	logic                              issued_s1;

	logic [PGW-1:0]                    page;
	logic [tlbpf_pkg::OFFSET_BITS-1:0] offset;
	logic                              tlb_hit;
	logic [FIW-1:0]                    tlb_frame;
	logic [FIW-1:0]                    rd_addr;
	logic [CMW-1:0]                    cfg_ext;
	logic [CMW-1:0]                    limit;
	logic [CMW-1:0]                    nv_ext;
	logic [CMW-1:0]                    vf_ext;
	logic [CMW-1:0]                    vf_inc;
	logic [FIW-1:0]                    victim_frame;
	logic [FIW-1:0]                    nv_nxt;
	logic [FIW+tlbpf_pkg::OFFSET_BITS-1:0] pa_cat;

	assign page   = addr_q[tlbpf_pkg::ADDR_W-1:tlbpf_pkg::OFFSET_BITS];
	assign offset = addr_q[tlbpf_pkg::OFFSET_BITS-1:0];

	// Search the TLB, lowest matching entry wins
	always_comb begin
		tlb_hit   = 1'b0;
		tlb_frame = '0;
		for (int i = tlbpf_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tlb_valid_q[i] && (tlb_tag_q[i] == page)) begin
				tlb_hit   = 1'b1;
				tlb_frame = tlb_frame_q[i];
			end
		end
	end

	// Clamp the frame count and pick the next round-robin frame
	always_comb begin
		cfg_ext = CMW'(cfg_q);
		if (cfg_ext == '0) begin
			limit = CMW'(1);
		end else if (cfg_ext > CMW'(tlbpf_pkg::FRAME_COUNT)) begin
			limit = CMW'(tlbpf_pkg::FRAME_COUNT);
		end else begin
			limit = cfg_ext;
		end
		nv_ext       = CMW'(nv_q);
		vf_ext       = (nv_ext >= limit) ? '0 : nv_ext;
		vf_inc       = vf_ext + CMW'(1);
		victim_frame = FIW'(vf_ext);
		nv_nxt       = (vf_inc >= limit) ? '0 : FIW'(vf_inc);
	end

	assign rd_addr = cmd.victim_read ? victim_frame : walk_idx_q;

	// Status back to the controller
	assign status.tlb_hit   = tlb_hit;
	assign status.walk_hit  = issued_s1 && own_vld_s1 && (owner_rd_s1 == page);
	assign status.walk_last = issued_s1 && (idx_s1 == FIW'(tlbpf_pkg::FRAME_COUNT - 1));
	assign status.out_free  = !out_valid || out_ready;

	// Owner table: one read or one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.fault_commit) begin
			owner_mem[frame_q] <= page;
		end
		if (cmd.walk_issue || cmd.victim_read) begin
			owner_rd_s1 <= owner_mem[rd_addr];
		end
	end

	// Control state: valid bits, pointers, register, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q         <= tlbpf_pkg::CFG_RESET;
			tlb_valid_q   <= '0;
			fill_q        <= '0;
			frame_valid_q <= '0;
			walk_idx_q    <= '0;
			nv_q          <= '0;
			issued_s1     <= 1'b0;
			own_vld_s1    <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			// Restart the walk at frame zero
			if (cmd.walk_clear) begin
				walk_idx_q <= '0;
				issued_s1  <= 1'b0;
			end
			// Advance the walk one frame a cycle
			if (cmd.walk_issue) begin
				walk_idx_q <= walk_idx_q + FIW'(1);
				issued_s1  <= 1'b1;
			end
			if (cmd.walk_issue || cmd.victim_read) begin
				own_vld_s1 <= frame_valid_q[rd_addr];
			end
			if (cmd.victim_read) begin
				nv_q <= nv_nxt;
			end
			// Insert at the fill slot, drop stale TLB entries of the evicted frame
			if (cmd.fault_commit) begin
				for (int i = 0; i < tlbpf_pkg::TLB_ENTRIES; i++) begin
					if (TIW'(i) == fill_q) begin
						tlb_valid_q[i] <= 1'b1;
					end else if (own_vld_s1 && tlb_valid_q[i] &&
							(tlb_frame_q[i] == frame_q)) begin
						tlb_valid_q[i] <= 1'b0;
					end
				end
				frame_valid_q[frame_q] <= 1'b1;
				fill_q <= (fill_q == TIW'(tlbpf_pkg::TLB_ENTRIES - 1)) ? '0 : fill_q + TIW'(1);
			end
			// Hold the result until it is taken
			if (cmd.res_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign pa_cat = {frame_q, offset};

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q     <= in_addr;
			vic_vld_q  <= 1'b0;
			vic_page_q <= '0;
		end
		if (cmd.walk_issue) begin
			idx_s1 <= walk_idx_q;
		end
		unique case (cmd.frame_sel)
			tlbpf_pkg::FS_TLB: begin
				frame_q   <= tlb_frame;
				outcome_q <= tlbpf_pkg::OUT_TLB_HIT;
			end
			tlbpf_pkg::FS_WALK: begin
				frame_q   <= idx_s1;
				outcome_q <= tlbpf_pkg::OUT_PT_HIT;
			end
			tlbpf_pkg::FS_VICTIM: begin
				frame_q   <= victim_frame;
				outcome_q <= tlbpf_pkg::OUT_FAULT;
			end
			tlbpf_pkg::FS_NONE: begin
			end
			default: begin
			end
		endcase
		if (cmd.fault_commit) begin
			vic_vld_q  <= own_vld_s1;
			vic_page_q <= own_vld_s1 ? tlbpf_pkg::VPAGE_W'(owner_rd_s1) : '0;
		end
		if (cmd.fault_commit) begin
			tlb_tag_q[fill_q]   <= page;
			tlb_frame_q[fill_q] <= frame_q;
		end
		if (cmd.res_load) begin
			out_pa        <= tlbpf_pkg::PA_W'(pa_cat);
			out_outcome   <= outcome_q;
			out_vic_valid <= vic_vld_q;
			out_vic_page  <= vic_page_q;
		end
	end

endmodule

// ===== rtl/tlb_page_translation_fifo.sv =====
// Channel   Dir  Handshake          Contents
// s_axis    in   s_tvalid/s_tready  s_tdata: vaddr
// m_axis    out  m_tvalid/m_tready  m_tdata: paddr, victim_page
//                                   m_tuser: outcome, victim_valid
// cfg       in   cfg_we             cfg_wdata: frames_in_use
//
// One request at a time. A TLB hit goes from lookup to the done state, which
// loads the output register; a page table hit or a fault waits on the walk
// over the owner table, one frame a cycle through its single read port, and a
// fault then reads and commits the victim frame. Reset clears all valid bits
// at once, so the block is ready out of reset. A result waiting on m_tready
// does not block the next request, which waits only to load the output.
module tlb_page_translation_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] vaddr
	input  logic [tlbpf_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [14:0] paddr, [22:15] victim_page, [23] zero
	output logic [tlbpf_pkg::M_TDATA_W-1:0]     m_tdata,
	// [1:0] outcome, [2] victim_valid
	output logic [tlbpf_pkg::M_TUSER_W-1:0]     m_tuser,
	input  logic                                cfg_we,
	input  logic [tlbpf_pkg::CFG_W-1:0]         cfg_wdata
);

`include "tlb_page_translation_fifo_assert.svh"

	tlbpf_pkg::ctrl_cmd_t             cmd;
	tlbpf_pkg::dp_status_t            status;
	logic [tlbpf_pkg::PA_W-1:0]       out_pa;
	logic [tlbpf_pkg::OUTCOME_W-1:0]  out_outcome;
	logic                             out_vic_valid;
	logic [tlbpf_pkg::VPAGE_W-1:0]    out_vic_page;

	tlbpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tlbpf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_addr       (s_tdata),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_pa        (out_pa),
		.out_outcome   (out_outcome),
		.out_vic_valid (out_vic_valid),
		.out_vic_page  (out_vic_page)
	);

	// Pack the result
	assign m_tdata = {{tlbpf_pkg::M_PAD_W{1'b0}}, out_vic_page, out_pa};
	assign m_tuser = {out_vic_valid, out_outcome};

	`TPTF_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second request taken during a translation")
	`TPTF_ASSERT_NOW(a_load_free, cmd.res_load, !m_tvalid || m_tready, "result loaded over a pending one")
	`TPTF_ASSERT_NOW(a_hit_no_victim, m_tvalid && (m_tuser[1:0] != tlbpf_pkg::OUT_FAULT), !m_tuser[2] && (m_tdata[22:15] == 8'd0), "hit reports a victim")

endmodule

// ===== test/tlb_page_translation_fifo_tb.sv =====
`timescale 1ns / 1ps

module tlb_page_translation_fifo_tb;
	import tlbpf_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 160;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		logic [PA_W-1:0]    phys_addr;
		outcome_t           outcome;
		logic               victim_valid;
		logic [VPAGE_W-1:0] victim_page;
	} translation_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;

	tlb_page_translation_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the translation state
	logic [PAGE_W-1:0]      tlb_tag [TLB_ENTRIES];
	bit                     tlb_live [TLB_ENTRIES];
	logic [FRAME_IDX_W-1:0] tlb_frame [TLB_ENTRIES];
	logic [TLB_IDX_W-1:0]   tlb_fill;
	logic [PAGE_W-1:0]      owner_page [FRAME_COUNT];
	bit                     owner_live [FRAME_COUNT];
	int                     victim_frame;
	logic [CFG_W-1:0]       frames_setting;

	translation_t pending_translations[$];
	int           mismatch_count;
	int           cycle_count;
	int           ready_hold;
	bit           steady_flow;

	// Free-running clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Translate one address and update the shadow state
	function automatic translation_t predict_translation(input logic [ADDR_W-1:0] la);
		logic [PAGE_W-1:0]      page;
		logic [OFFSET_BITS-1:0] offset;
		int                     frame;
		int                     limit;
		bit                     found;
		translation_t           res;
		page = la[ADDR_W-1:OFFSET_BITS];
		offset = la[OFFSET_BITS-1:0];
		frame = 0;
		found = 1'b0;
		res.outcome = OUT_FAULT;
		res.victim_valid = 1'b0;
		res.victim_page = '0;
		// search the TLB, lowest index wins
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (!found && tlb_live[i] && tlb_tag[i] == page) begin
				frame = tlb_frame[i];
				res.outcome = OUT_TLB_HIT;
				found = 1'b1;
			end
		end
		// walk the owner table
		for (int i = 0; i < FRAME_COUNT; i++) begin
			if (!found && owner_live[i] && owner_page[i] == page) begin
				frame = i;
				res.outcome = OUT_PT_HIT;
				found = 1'b1;
			end
		end
		// fault: take the next frame round-robin, clamp the frame count
		if (!found) begin
			limit = frames_setting;
			if (limit == 0)
				limit = 1;
			if (limit > FRAME_COUNT)
				limit = FRAME_COUNT;
			frame = victim_frame;
			if (frame >= limit)
				frame = 0;
			victim_frame = (frame + 1 >= limit) ? 0 : frame + 1;
			if (owner_live[frame]) begin
				res.victim_valid = 1'b1;
				res.victim_page = owner_page[frame];
				for (int i = 0; i < TLB_ENTRIES; i++) begin
					if (tlb_live[i] && tlb_frame[i] == frame)
						tlb_live[i] = 1'b0;
				end
			end
			owner_page[frame] = page;
			owner_live[frame] = 1'b1;
			tlb_tag[tlb_fill] = page;
			tlb_frame[tlb_fill] = FRAME_IDX_W'(frame);
			tlb_live[tlb_fill] = 1'b1;
			tlb_fill = tlb_fill + 1'b1;
		end
		res.phys_addr = PA_W'((frame << OFFSET_BITS) + offset);
		return res;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Send one request after a random gap; predict it once accepted
	task automatic send_request(input logic [ADDR_W-1:0] la);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= la;
		do
			@(posedge clk);
		while (!s_tready);
		pending_translations.push_back(predict_translation(la));
	endtask

	// Write the frame count once every result is back
	task automatic set_frames(input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_translations.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		frames_setting = value;
	endtask

	// Compare each result and pace the receiver
	always @(posedge clk) begin : result_check
		translation_t want;
		translation_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.phys_addr = m_tdata[PA_W-1:0];
				got.victim_page = m_tdata[PA_W +: VPAGE_W];
				got.outcome = outcome_t'(m_tuser[OUTCOME_W-1:0]);
				got.victim_valid = m_tuser[OUTCOME_W];
				if (pending_translations.size() == 0) begin
					note_mismatch($sformatf("result with nothing pending: pa=%h",
						got.phys_addr));
				end else begin
					want = pending_translations.pop_front();
					if (got.phys_addr !== want.phys_addr || got.outcome !== want.outcome ||
							got.victim_valid !== want.victim_valid ||
							got.victim_page !== want.victim_page)
						note_mismatch($sformatf(
							"expected pa=%h outcome=%0d vv=%b vp=%h, got pa=%h outcome=%0d vv=%b vp=%h",
							want.phys_addr, want.outcome, want.victim_valid, want.victim_page,
							got.phys_addr, got.outcome, got.victim_valid, got.victim_page));
				end
				ready_hold = steady_flow ? 0 : $urandom_range(0, 3);
				m_tready <= (ready_hold == 0);
			end else if (ready_hold > 0) begin
				ready_hold--;
				m_tready <= (ready_hold == 0);
			end
		end
	end

	// Hard stop on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Fault into free frames at the address extremes, then hit them in the TLB
	task automatic test_tlb_hits();
		send_request(16'h0000);
		send_request(16'h00FF);
		send_request(16'hFFFF);
		send_request(16'hFF00);
	endtask

	// Age page 0 out of the TLB so that the walk finds it
	task automatic test_table_hit();
		for (int p = 1; p <= 15; p++)
			send_request({PAGE_W'(p), OFFSET_BITS'($urandom)});
		send_request(16'h0012);
	endtask

	// Shrink, zero and oversized frame counts
	task automatic test_frame_limits();
		// shrunk count: the fault wraps to frame 0 and evicts its page
		set_frames(8'd4);
		send_request(16'h2000);
		// page in a frame above the count still hits
		send_request(16'h0F7E);
		// zero acts as one frame
		set_frames(8'd0);
		send_request(16'h2155);
		// above the frame count acts as the full count
		set_frames(8'd255);
		send_request(16'h22AA);
	endtask

	// Working-set traffic with random content, over several frame counts
	task automatic test_random_traffic();
		logic [CFG_W-1:0]  settings [12] = '{8'd128, 8'd1, 8'd2, 8'd16, 8'd0, 8'd200,
			8'd255, 8'd64, 8'd3, 8'd127, 8'd40, 8'd128};
		int                ws;
		logic [PAGE_W-1:0] base;
		logic [PAGE_W-1:0] page;
		foreach (settings[p]) begin
			set_frames(settings[p]);
			steady_flow = ($urandom_range(0, 3) == 0);
			ws = $urandom_range(2, 40);
			base = PAGE_W'($urandom);
			repeat (108) begin
				// drift the working set now and then
				if ($urandom_range(0, 29) == 0)
					base = PAGE_W'($urandom);
				if ($urandom_range(0, 99) < 85)
					page = base + PAGE_W'($urandom_range(0, ws - 1));
				else
					page = PAGE_W'($urandom);
				send_request({page, OFFSET_BITS'($urandom)});
			end
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		steady_flow = 1'b0;
		ready_hold = 0;
		mismatch_count = 0;
		cycle_count = 0;
		// clear the shadow state
		foreach (tlb_live[i]) begin
			tlb_live[i] = 1'b0;
			tlb_tag[i] = '0;
			tlb_frame[i] = '0;
		end
		foreach (owner_live[i]) begin
			owner_live[i] = 1'b0;
			owner_page[i] = '0;
		end
		tlb_fill = '0;
		victim_frame = 0;
		frames_setting = CFG_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_tlb_hits();
		test_table_hit();
		test_frame_limits();
		test_random_traffic();

		// drain outstanding results
		s_tvalid <= 1'b0;
		while (pending_translations.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_translations.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tlbpf_pkg.sv
rtl/tlbpf_ctrl.sv
rtl/tlbpf_dp.sv
rtl/tlb_page_translation_fifo.sv
test/tlb_page_translation_fifo_tb.sv
